[sv/wil_pkg.sv]
package wil_pkg;

    // longest window in use
    localparam int MAX_LENGTH   = 65536;

    // cell counts and pipeline depths
    localparam int MOD_CELLS    = 16;
    localparam int DIV_CELLS    = 30;
    localparam int HORNER_STEPS = 5;
    localparam int POINT_LAT    = DIV_CELLS + 2 * HORNER_STEPS + 6;
    localparam int SIDE_DLY     = MOD_CELLS + 1 + POINT_LAT;
    localparam int LATENCY      = SIDE_DLY + 2;

    // fixed point constants
    localparam logic [30:0] ONE_Q30  = 31'd1073741824;
    localparam logic [29:0] ONE_Q28  = 30'd268435456;
    localparam logic [29:0] HALF_Q28 = 30'd134217728;
    localparam logic [29:0] TWO_Q28  = 30'd536870912;
    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [16:0] UNIT_Q16 = 17'd65536;
    localparam logic [16:0] TAPER_MAX = 17'd65536;

    // shape codes
    localparam logic [1:0] SHAPE_RECT  = 2'd0;
    localparam logic [1:0] SHAPE_HANN  = 2'd1;
    localparam logic [1:0] SHAPE_TUKEY = 2'd2;

    // horner divisors by reciprocal: q = (y * M) >> S, exact for 32-bit y
    localparam int HDIV_S [HORNER_STEPS] = '{40, 39, 38, 37, 36};
    localparam logic [63:0] HDIV_M [HORNER_STEPS] = '{
        (64'd1 << 40) / 64'd132 + 64'd1,
        (64'd1 << 39) / 64'd90  + 64'd1,
        (64'd1 << 38) / 64'd56  + 64'd1,
        (64'd1 << 37) / 64'd30  + 64'd1,
        (64'd1 << 36) / 64'd12  + 64'd1
    };

    typedef enum logic [1:0] {
        REG_SHAPE  = 2'd0,
        REG_LENGTH = 2'd1,
        REG_TAPER  = 2'd2
    } wil_reg_t;

    typedef enum logic [1:0] {
        KIND_UNIT,
        KIND_ZERO,
        KIND_CALC
    } wil_kind_t;

    // settled configuration seen by the datapath
    typedef struct packed {
        logic [1:0]  shape;
        logic [16:0] len;
        logic        len_zero;
        logic        len_lt2;
        logic [15:0] lm1;
        logic        a_zero;
        logic [31:0] tq;
        logic [31:0] den;
    } wil_cfg_t;

    typedef struct packed {
        logic [16:0] rem;
        logic [15:0] num;
        logic        neg;
    } wil_mod_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [29:0] q;
    } wil_div_t;

endpackage

[sv/wil_mod_cell.sv]
module wil_mod_cell (
    input  logic             clk,
    input  logic [16:0]      len,
    input  wil_pkg::wil_mod_t din,
    output wil_pkg::wil_mod_t dout
);
    import wil_pkg::*;

    wil_mod_t    dout_reg;
    wil_mod_t    dout_next;
    logic [17:0] trial;
    logic [17:0] diff;

    // one restoring step: bring in the next index bit, subtract length if it fits
    always_comb
    begin
        trial = {din.rem, din.num[15]};
        diff  = trial - {1'b0, len};
        dout_next.rem = (trial >= {1'b0, len}) ? diff[16:0] : trial[16:0];
        dout_next.num = {din.num[14:0], 1'b0};
        dout_next.neg = din.neg;
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

[sv/wil_div_cell.sv]
module wil_div_cell (
    input  logic             clk,
    input  logic [31:0]      den,
    input  wil_pkg::wil_div_t din,
    output wil_pkg::wil_div_t dout
);
    import wil_pkg::*;

    wil_div_t    dout_reg;
    wil_div_t    dout_next;
    logic [33:0] trial;
    logic [33:0] diff;
    logic        fits;

    // one quotient bit per cell
    always_comb
    begin
        trial = {din.rem, 1'b0};
        diff  = trial - {2'b0, den};
        fits  = trial >= {2'b0, den};
        dout_next.rem = fits ? diff[32:0] : trial[32:0];
        dout_next.q   = {din.q[28:0], fits};
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

[sv/wil_horner_cell.sv]
module wil_horner_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic        clk,
    input  logic [31:0] x2_in,
    input  logic [30:0] t_in,
    output logic [31:0] x2_out,
    output logic [30:0] t_out
);
    import wil_pkg::*;

    localparam logic [32:0] MUL   = HDIV_M[STEP][32:0];
    localparam int          SHIFT = HDIV_S[STEP];

    logic [62:0] prod;
    logic [65:0] qprod;
    logic [65:0] qshift;
    logic [31:0] y_reg;
    logic [31:0] y_next;
    logic [31:0] x2_mid_reg;
    logic [31:0] x2_out_reg;
    logic [30:0] t_reg;
    logic [30:0] t_next;

    // first half: x2 * t in q30
    always_comb
    begin
        prod   = {31'b0, x2_in} * {32'b0, t_in};
        y_next = prod[61:30];
    end

    // second half: divide by the step constant, then 1 - quotient
    always_comb
    begin
        qprod  = {34'b0, y_reg} * {33'b0, MUL};
        qshift = qprod >> SHIFT;
        t_next = ONE_Q30 - qshift[30:0];
    end

    always_ff @(posedge clk)
    begin
        y_reg      <= y_next;
        x2_mid_reg <= x2_in;
        t_reg      <= t_next;
        x2_out_reg <= x2_mid_reg;
    end

    assign x2_out = x2_out_reg;
    assign t_out  = t_reg;

endmodule

[sv/wil_point.sv]
module wil_point (
    input  logic             clk,
    input  wil_pkg::wil_cfg_t cfg,
    input  logic [15:0]      n,
    output logic [16:0]      s
);
    import wil_pkg::*;

    localparam int KIND_DLY = DIV_CELLS + 2 * HORNER_STEPS + 4;
    localparam int HI_DLY   = 2 * HORNER_STEPS + 3;

    wil_kind_t   kind_next;
    wil_kind_t   kind_reg;
    wil_kind_t   kind_dly_reg [KIND_DLY];
    logic [15:0] v_next;
    logic [15:0] v_reg;
    logic [15:0] m;
    logic        hann;

    wil_div_t    div_bus [DIV_CELLS+1];

    logic [29:0] q;
    logic [29:0] qf;
    logic [29:0] rfull;
    logic        hi_next;
    logic        hi_reg;
    logic        hi_dly_reg [HI_DLY];
    logic [27:0] r_next;
    logic [27:0] r_reg;

    logic [59:0] xprod;
    logic [30:0] x_reg;
    logic [61:0] x2prod;
    logic [31:0] x2_reg;

    logic [31:0] hx2 [HORNER_STEPS+1];
    logic [30:0] ht  [HORNER_STEPS+1];

    logic [62:0] pprod;
    logic [31:0] p_reg;
    logic [30:0] c;
    logic [31:0] rc;
    logic [31:0] rnd;
    logic [16:0] s_next;
    logic [16:0] s_reg;

    assign hann = (cfg.shape == SHAPE_HANN);

    // classify the point and pick the phase numerator
    always_comb
    begin
        m         = cfg.lm1 - n;
        kind_next = KIND_UNIT;
        v_next    = '0;
        unique case (cfg.shape)
            SHAPE_HANN:
            begin
                if (cfg.len_lt2)
                    kind_next = KIND_ZERO;
                else
                begin
                    kind_next = KIND_CALC;
                    v_next    = n;
                end
            end
            SHAPE_TUKEY:
            begin
                if (cfg.len_lt2)
                    kind_next = KIND_ZERO;
                else if (cfg.a_zero)
                    kind_next = KIND_UNIT;
                else if ({n, 17'b0} < {1'b0, cfg.tq})
                begin
                    kind_next = KIND_CALC;
                    v_next    = n;
                end
                else if ({m, 17'b0} >= {1'b0, cfg.tq})
                    kind_next = KIND_UNIT;
                else
                begin
                    kind_next = KIND_CALC;
                    v_next    = m;
                end
            end
            default:
                kind_next = KIND_UNIT;
        endcase
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        v_reg    <= v_next;
    end

    // phase division chain: q = (v << 45) / den
    assign div_bus[0].rem = {2'b0, v_reg, 15'b0};
    assign div_bus[0].q   = '0;

    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_div
        wil_div_cell u_div (
            .clk  (clk),
            .den  (cfg.den),
            .din  (div_bus[i]),
            .dout (div_bus[i+1])
        );
    end

    // fold hann phase, pick the half of the cosine
    always_comb
    begin
        q       = div_bus[DIV_CELLS].q;
        qf      = (hann && (q > ONE_Q28)) ? (TWO_Q28 - q) : q;
        hi_next = qf > HALF_Q28;
        rfull   = hi_next ? (ONE_Q28 - qf) : qf;
        r_next  = rfull[27:0];
    end

    // angle and its square
    always_comb
    begin
        xprod  = {32'b0, r_reg} * {28'b0, PI_Q30};
        x2prod = {31'b0, x_reg} * {31'b0, x_reg};
    end

    always_ff @(posedge clk)
    begin
        r_reg  <= r_next;
        hi_reg <= hi_next;
        x_reg  <= xprod[58:28];
        x2_reg <= x2prod[61:30];
    end

    // taylor series by horner steps
    assign hx2[0] = x2_reg;
    assign ht[0]  = ONE_Q30;

    for (genvar k = 0; k < HORNER_STEPS; k++)
    begin : g_horner
        wil_horner_cell #(.STEP(k)) u_horner (
            .clk    (clk),
            .x2_in  (hx2[k]),
            .t_in   (ht[k]),
            .x2_out (hx2[k+1]),
            .t_out  (ht[k+1])
        );
    end

    // last product and halving
    assign pprod = {31'b0, hx2[HORNER_STEPS]} * {32'b0, ht[HORNER_STEPS]};

    always_ff @(posedge clk)
    begin
        p_reg <= pprod[62:31];
    end

    // cosine clamp, raised cosine, round to q16
    always_comb
    begin
        c      = (p_reg >= {1'b0, ONE_Q30}) ? 31'd0 : (ONE_Q30 - p_reg[30:0]);
        rc     = hi_dly_reg[HI_DLY-1] ? (({1'b0, ONE_Q30} + {1'b0, c}) >> 1)
                                      : (({1'b0, ONE_Q30} - {1'b0, c}) >> 1);
        rnd    = (rc + 32'd8192) >> 14;
        case (kind_dly_reg[KIND_DLY-1])
            KIND_ZERO: s_next = '0;
            KIND_CALC: s_next = rnd[16:0];
            default:   s_next = UNIT_Q16;
        endcase
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
    end

    // side flags follow the data
    always_ff @(posedge clk)
    begin
        kind_dly_reg[0] <= kind_reg;
        for (int i = 1; i < KIND_DLY; i++)
            kind_dly_reg[i] <= kind_dly_reg[i-1];
        hi_dly_reg[0] <= hi_reg;
        for (int i = 1; i < HI_DLY; i++)
            hi_dly_reg[i] <= hi_dly_reg[i-1];
    end

    assign s = s_reg;

endmodule

[sv/window_interpolated_lookup.sv]
// Throughput: one request per clock; busy stays low and results cannot be held off.
// The depth is set by the 16-cell index wrap chain, the 30-cell phase divider chain and
// the 5 two-stage horner cells of the cosine series.
// Reset: rst_n clears the request pipeline valid bits and loads the register defaults
// (rectangular shape, length 1024, taper 52429).
module window_interpolated_lookup (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] read_index,
    output logic        done,
    output logic [16:0] window_value,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import wil_pkg::*;

    logic [1:0]  shape_reg;
    logic [16:0] length_reg;
    logic [16:0] taper_reg;

    wil_cfg_t    cfg_next;
    wil_cfg_t    cfg_reg;
    logic [16:0] a_sat;
    logic [32:0] tq_full;

    logic        take;
    logic        vld_a_reg;
    wil_mod_t    mod_a_reg;
    wil_mod_t    mod_a_next;
    logic [15:0] frac_a_reg;
    logic [15:0] ip;

    wil_mod_t    mod_bus [MOD_CELLS+1];

    logic [16:0] i0_full;
    logic [16:0] i1_full;
    logic [15:0] i0_reg;
    logic [15:0] i1_reg;

    logic        vld_dly_reg  [SIDE_DLY];
    logic [15:0] frac_dly_reg [SIDE_DLY];

    logic [16:0] s0;
    logic [16:0] s1;
    logic [16:0] wfrac;
    logic [33:0] mul0;
    logic [33:0] mul1;
    logic [34:0] acc;
    logic [16:0] value_next;
    logic [16:0] window_value_reg;
    logic        done_reg;

    assign busy = 1'b0;
    assign take = start & ~busy;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg  <= SHAPE_RECT;
            length_reg <= 17'd1024;
            taper_reg  <= 17'd52429;
        end
        else if (cfg_write)
        begin
            unique case (wil_reg_t'(cfg_index))
                REG_SHAPE:  shape_reg  <= cfg_data[1:0];
                REG_LENGTH: length_reg <= cfg_data;
                REG_TAPER:  taper_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // derived configuration, settled in the cycle after a write
    always_comb
    begin
        cfg_next.shape    = shape_reg;
        cfg_next.len      = ({4'b0, length_reg} > 21'(MAX_LENGTH)) ? 17'(MAX_LENGTH)
                                                                   : length_reg;
        cfg_next.len_zero = (cfg_next.len == 17'd0);
        cfg_next.len_lt2  = (cfg_next.len < 17'd2);
        cfg_next.lm1      = 16'(cfg_next.len - 17'd1);
        a_sat             = (taper_reg > TAPER_MAX) ? TAPER_MAX : taper_reg;
        cfg_next.a_zero   = (a_sat == 17'd0);
        tq_full           = a_sat * {1'b0, cfg_next.lm1};
        cfg_next.tq       = tq_full[31:0];
        cfg_next.den      = (shape_reg == SHAPE_HANN) ? {cfg_next.lm1, 16'b0} : cfg_next.tq;
    end

    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    // request capture: magnitude of the integer part, sign and fraction
    always_comb
    begin
        ip             = read_index[31:16];
        mod_a_next.neg = read_index[31];
        mod_a_next.num = read_index[31] ? (~ip + 16'd1) : ip;
        mod_a_next.rem = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_a_reg <= 1'b0;
        else
            vld_a_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        mod_a_reg  <= mod_a_next;
        frac_a_reg <= read_index[15:0];
    end

    // index wrap chain
    assign mod_bus[0] = mod_a_reg;

    for (genvar i = 0; i < MOD_CELLS; i++)
    begin : g_mod
        wil_mod_cell u_mod (
            .clk  (clk),
            .len  (cfg_reg.len),
            .din  (mod_bus[i]),
            .dout (mod_bus[i+1])
        );
    end

    // floor remainder and upper neighbor
    always_comb
    begin
        i0_full = (mod_bus[MOD_CELLS].neg && (mod_bus[MOD_CELLS].rem != 17'd0))
                  ? (cfg_reg.len - mod_bus[MOD_CELLS].rem) : mod_bus[MOD_CELLS].rem;
        i1_full = ((i0_full + 17'd1) == cfg_reg.len) ? 17'd0 : (i0_full + 17'd1);
    end

    always_ff @(posedge clk)
    begin
        i0_reg <= i0_full[15:0];
        i1_reg <= i1_full[15:0];
    end

    // window points
    wil_point u_pt0 (
        .clk (clk),
        .cfg (cfg_reg),
        .n   (i0_reg),
        .s   (s0)
    );

    wil_point u_pt1 (
        .clk (clk),
        .cfg (cfg_reg),
        .n   (i1_reg),
        .s   (s1)
    );

    // request valid and fraction ride alongside
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SIDE_DLY; i++)
                vld_dly_reg[i] <= 1'b0;
        end
        else
        begin
            vld_dly_reg[0] <= vld_a_reg;
            for (int i = 1; i < SIDE_DLY; i++)
                vld_dly_reg[i] <= vld_dly_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        frac_dly_reg[0] <= frac_a_reg;
        for (int i = 1; i < SIDE_DLY; i++)
            frac_dly_reg[i] <= frac_dly_reg[i-1];
    end

    // linear interpolation
    always_comb
    begin
        wfrac      = {1'b0, frac_dly_reg[SIDE_DLY-1]};
        mul0       = s0 * (UNIT_Q16 - wfrac);
        mul1       = s1 * wfrac;
        acc        = {1'b0, mul0} + {1'b0, mul1} + 35'd32768;
        value_next = cfg_reg.len_zero ? 17'd0 : acc[32:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_dly_reg[SIDE_DLY-1];
    end

    always_ff @(posedge clk)
    begin
        window_value_reg <= value_next;
    end

    assign done         = done_reg;
    assign window_value = window_value_reg;

endmodule

[sv/wil_checker.sv]
module wil_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [16:0] window_value
);
    import wil_pkg::*;

    // every request comes back after the fixed pipeline depth
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request did not complete on time");

    // no result without a matching request
    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without request");

    // gain never exceeds unity
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (window_value <= UNIT_Q16))
        else $error("window gain above one");

    // the block never stalls requests
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind window_interpolated_lookup wil_checker u_wil_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .window_value (window_value)
);

[sim/tb.sv]
module tb;

    import wil_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [1:0] SHAPE_SPARE = 2'd3;

    // expected window gains and a private copy of the register state
    class lookup_scoreboard;
        bit [1:0]   shape;
        bit [16:0]  length;
        bit [16:0]  taper;
        bit [16:0]  pending_gain[$];
        int         errors;
        int         checked;

        function new();
            shape   = SHAPE_RECT;
            length  = 17'd1024;
            taper   = 17'd52429;
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(bit [1:0] idx, bit [16:0] data);
            if (idx == REG_SHAPE)
                shape = data[1:0];
            else if (idx == REG_LENGTH)
                length = data;
            else if (idx == REG_TAPER)
                taper = data;
        endfunction

        // cos(pi*r) in q30, r in q0.28 up to one half
        function bit [63:0] cos_half(bit [63:0] r);
            bit [63:0] divs [5];
            bit [63:0] x;
            bit [63:0] x2;
            bit [63:0] t;
            bit [63:0] p;
            divs = '{64'd132, 64'd90, 64'd56, 64'd30, 64'd12};
            x  = (r * 64'd3373259426) >> 28;
            x2 = (x * x) >> 30;
            t  = 64'd1073741824;
            for (int k = 0; k < 5; k++)
                t = 64'd1073741824 - ((x2 * t) >> 30) / divs[k];
            p = ((x2 * t) >> 30) >> 1;
            return (p >= 64'd1073741824) ? 64'd0 : 64'd1073741824 - p;
        endfunction

        // raised cosine point in q1.16 from phase q in q0.28
        function bit [63:0] taper_gain(bit [63:0] q);
            bit [63:0] v;
            if (q > 64'd268435456)
                q = 64'd268435456;
            if (q <= 64'd134217728)
                v = (64'd1073741824 - cos_half(q)) >> 1;
            else
                v = (64'd1073741824 + cos_half(64'd268435456 - q)) >> 1;
            return (v + 64'd8192) >> 14;
        endfunction

        function bit [63:0] point_gain(bit [63:0] n, bit [63:0] len);
            bit [63:0] q;
            bit [63:0] a;
            bit [63:0] tq;
            bit [63:0] m;
            if (shape == SHAPE_HANN)
            begin
                if (len < 2)
                    return 0;
                q = (n << 29) / (len - 1);
                if (q > 64'd268435456)
                    q = 64'd536870912 - q;
                return taper_gain(q);
            end
            if (shape == SHAPE_TUKEY)
            begin
                if (len < 2)
                    return 0;
                a = (taper > 17'd65536) ? 64'd65536 : 64'(taper);
                if (a == 0)
                    return 64'd65536;
                tq = a * (len - 1);
                m  = len - 1 - n;
                // rising taper takes priority on short windows
                if ((n << 17) < tq)
                    q = (n << 45) / tq;
                else if ((m << 17) >= tq)
                    return 64'd65536;
                else
                    q = (m << 45) / tq;
                return taper_gain(q);
            end
            return 64'd65536;
        endfunction

        function bit [16:0] interp_gain(bit [31:0] idx);
            bit [63:0] len;
            longint    pos;
            longint    span;
            longint    w;
            bit [63:0] i0;
            bit [63:0] i1;
            bit [63:0] frac;
            bit [63:0] s0;
            bit [63:0] s1;
            len = (length > 17'd65536) ? 64'd65536 : 64'(length);
            if (len == 0)
                return 17'd0;
            pos  = longint'($signed(idx));
            span = longint'(len << 16);
            w    = pos % span;
            if (w < 0)
                w += span;
            i0   = 64'(w) >> 16;
            frac = 64'(w) & 64'hFFFF;
            i1   = (i0 + 1 == len) ? 64'd0 : i0 + 1;
            s0   = point_gain(i0, len);
            s1   = point_gain(i1, len);
            return 17'((s0 * (64'd65536 - frac) + s1 * frac + 64'd32768) >> 16);
        endfunction

        function void note_request(bit [31:0] idx);
            pending_gain.push_back(interp_gain(idx));
        endfunction

        function void check_result(bit [16:0] gain);
            bit [16:0] want;
            if (pending_gain.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d", $time, gain);
                errors++;
                return;
            end
            want = pending_gain.pop_front();
            checked++;
            if (gain !== want)
            begin
                $display("%0t: window_value mismatch, expected %0d, actual %0d",
                         $time, want, gain);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] read_index;
    logic        done;
    logic [16:0] window_value;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    lookup_scoreboard sb;
    bit  quiet;
    int  phases;

    window_interpolated_lookup dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .read_index   (read_index),
        .done         (done),
        .window_value (window_value),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // monitor: requests, register writes and results at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                sb.write_reg(cfg_index, cfg_data);
            if (start && !busy)
                sb.note_request(read_index);
            if (done)
                sb.check_result(window_value);
        end
    end

    // run limit
    initial
    begin
        #4000000;
        $display("window_interpolated_lookup test failed");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // one request; start stays high unless a gap follows
    task automatic send_request(input logic [31:0] idx);
        @(negedge clk);
        start      <= 1'b1;
        read_index <= idx;
        do
            @(posedge clk);
        while (busy);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            @(negedge clk);
            start      <= 1'b0;
            read_index <= $urandom;
            repeat ($urandom_range(0, 14))
                @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_gain.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic set_window(input logic [1:0] shp, input logic [16:0] len,
                              input logic [16:0] tap);
        drain();
        write_reg(REG_SHAPE, {15'd0, shp});
        write_reg(REG_LENGTH, len);
        write_reg(REG_TAPER, tap);
        end_writes();
        phases++;
    endtask

    // random position: mostly inside the window, some near edges, some anywhere
    function automatic logic [31:0] pick_index(input logic [16:0] len);
        int unsigned n;
        int unsigned sel;
        n   = (len == 0) ? 1 : ((len > 17'd65536) ? 65536 : int'(len));
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return {16'($urandom_range(0, n - 1)), 16'($urandom)};
        if (sel < 8)
            return ($urandom_range(0, 1) ? 32'(n - 1) : 32'd0) << 16 | $urandom_range(0, 65535);
        return $urandom;
    endfunction

    task automatic random_block(input int count, input logic [16:0] len);
        for (int i = 0; i < count; i++)
            send_request(pick_index(len));
    endtask

    initial
    begin
        logic [31:0] corners [12];
        logic [1:0]  shp;
        logic [16:0] len;
        logic [16:0] tap;
        sb         = new();
        quiet      = 1'b0;
        phases     = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        read_index = 32'd0;
        cfg_write  = 1'b0;
        cfg_index  = REG_SHAPE;
        cfg_data   = 17'd0;
        corners = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                    32'h0000_FFFF, 32'h0000_0001, 32'h0001_0000, 32'h03FF_8000,
                    32'h03FF_FFFF, 32'hFFFF_0000, 32'h0400_0000, 32'hFC00_0000};
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: rectangular, length 1024
        foreach (corners[i])
            send_request(corners[i]);

        // directed settings: each shape, degenerate lengths, taper extremes
        set_window(SHAPE_HANN, 17'd1024, 17'd0);
        foreach (corners[i])
            send_request(corners[i]);
        set_window(SHAPE_TUKEY, 17'd1024, 17'd52429);
        random_block(6, 17'd1024);
        set_window(SHAPE_HANN, 17'd1, 17'd0);
        random_block(3, 17'd1);
        set_window(SHAPE_TUKEY, 17'd1, 17'd65536);
        random_block(3, 17'd1);
        set_window(SHAPE_RECT, 17'd0, 17'd0);
        random_block(3, 17'd0);

        // index 3 is not a register and must change nothing
        drain();
        write_reg(REG_UNUSED, 17'h1FFFF);
        end_writes();

        // random phases with extremes mixed in
        for (int ph = 0; ph < 24; ph++)
        begin
            case (ph)
                0:
                begin
                    shp = SHAPE_TUKEY; len = 17'd2;      tap = 17'd65536;
                end
                1:
                begin
                    shp = SHAPE_TUKEY; len = 17'd65536;  tap = 17'h1FFFF;
                end
                2:
                begin
                    shp = SHAPE_HANN;  len = 17'h1FFFF;  tap = 17'd1;
                end
                3:
                begin
                    shp = SHAPE_SPARE; len = 17'd37;     tap = 17'd0;
                end
                4:
                begin
                    shp = SHAPE_TUKEY; len = 17'd3;      tap = 17'd1;
                end
                5:
                begin
                    shp = SHAPE_TUKEY; len = 17'd50;     tap = 17'd0;
                end
                6:
                begin
                    shp = SHAPE_HANN;  len = 17'd2;      tap = 17'd65537;
                end
                7:
                begin
                    shp = SHAPE_TUKEY; len = 17'd9;      tap = 17'd65537;
                end
                default:
                begin
                    shp = 2'($urandom_range(0, 3));
                    case ($urandom_range(0, 3))
                        0: len = 17'($urandom);
                        1: len = 17'($urandom_range(2, 1024));
                        default: len = 17'($urandom_range(2, 64));
                    endcase
                    tap = $urandom_range(0, 1) ? 17'($urandom)
                                               : 17'($urandom_range(0, 65536));
                end
            endcase
            set_window(shp, len, tap);
            if (ph >= 20)
                quiet = 1'b1;
            random_block(75, len);
        end

        drain();
        repeat (LATENCY + 10)
            @(posedge clk);
        $display("covered %0d window settings, %0d results checked, %0d errors",
                 phases, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending_gain.size() == 0)
            $display("window_interpolated_lookup test passed");
        else
            $display("window_interpolated_lookup test failed");
        $finish;
    end

endmodule

[window_interpolated_lookup.f]
sv/wil_pkg.sv
sv/wil_mod_cell.sv
sv/wil_div_cell.sv
sv/wil_horner_cell.sv
sv/wil_point.sv
sv/window_interpolated_lookup.sv
sv/wil_checker.sv
sim/tb.sv
